>>> rtl/xorshift_bank_range_draw_defines.svh
// Assertion helpers for the RTL datapath
`ifndef XORSHIFT_BANK_RANGE_DRAW_DEFINES_SVH
`define XORSHIFT_BANK_RANGE_DRAW_DEFINES_SVH

// same-cycle implication
`define XBRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xbrd check failed");

// next-cycle implication
`define XBRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xbrd check failed");

`endif

>>> rtl/xbrd_pkg.sv
package xbrd_pkg;

  localparam int LANES_DEF     = 32;
  localparam int MAX_TRIES_DEF = 1024;

  localparam int OP_W    = 2;
  localparam int LANE_W  = 5;
  localparam int STATE_W = 64;
  localparam int VAL_W   = 32;

  // lane, seed_value, range_low, range_high, value_mask, padded to bytes
  localparam int IN_TDATA_W  = 168;
  // drawn_value, lane_state
  localparam int OUT_TDATA_W = 96;

  localparam logic [OP_W-1:0] OP_SEED = 2'd0;
  localparam logic [OP_W-1:0] OP_DRAW = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  localparam int SH_A = 13;
  localparam int SH_B = 7;
  localparam int SH_C = 17;

  function automatic logic [STATE_W-1:0] xs_step(input logic [STATE_W-1:0] s);
    logic [STATE_W-1:0] t;
    t = s ^ (s << SH_A);
    t = t ^ (t >> SH_B);
    t = t ^ (t << SH_C);
    return t;
  endfunction

  typedef struct packed {
    logic capture;
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_draw;
    logic lane_ok;
    logic hit;
    logic last_try;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/xorshift_bank_range_draw.sv
// Bank of LANES 64-bit xorshift generators (13, 7, 17) with ranged draws.
// Input stream: in_tuser carries the operation (seed, draw, read; code 3
// reads), in_tdata the lane, seed and draw range/mask. Output stream: one
// item per input item, with drawn_value and lane_state in out_tdata and the
// give-up flag in out_tuser.
// One item is in work at a time. Seed and read pass the bank read, load
// and result registers before out_tvalid rises; a new item is taken only
// after the last one's result is registered. A draw on a lane in the bank
// then takes 1 to MAX_TRIES xorshift steps, one at a time, in the single
// step unit feeding the range compare; a draw that finds no value in
// MAX_TRIES steps returns zero, sets the flag and keeps the state reached.
// The next item is taken once the result sits in the output register, so a
// stalled receiver holds one result while the following item is accepted
// and worked on; that item then waits for the register to empty.
// Reset clears the control only; lanes hold nothing defined until seeded.
// A lane index at or beyond LANES changes nothing and returns all zeros.
module xorshift_bank_range_draw #(
  parameter int LANES     = xbrd_pkg::LANES_DEF,
  parameter int MAX_TRIES = xbrd_pkg::MAX_TRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // lane[4:0], seed_value[68:5], range_low[100:69], range_high[132:101],
  // value_mask[164:133], zero fill above
  input  logic [xbrd_pkg::IN_TDATA_W-1:0]   in_tdata,
  // operation[1:0]
  input  logic [xbrd_pkg::OP_W-1:0]         in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // drawn_value[31:0], lane_state[95:32]
  output logic [xbrd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // gave_up[0]
  output logic [0:0]                        out_tuser
);

  xbrd_pkg::cmd_t cmd;
  xbrd_pkg::sts_t sts;

  xbrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  xbrd_dp #(
    .LANES     (LANES),
    .MAX_TRIES (MAX_TRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> rtl/xbrd_dp.sv
`include "xorshift_bank_range_draw_defines.svh"

module xbrd_dp #(
  parameter int LANES     = xbrd_pkg::LANES_DEF,
  parameter int MAX_TRIES = xbrd_pkg::MAX_TRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [xbrd_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [xbrd_pkg::OP_W-1:0]          in_tuser,
  input  xbrd_pkg::cmd_t                     cmd,
  output xbrd_pkg::sts_t                     sts,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [xbrd_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [0:0]                         out_tuser
);

  localparam int LANE_AW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int TRY_W   = (MAX_TRIES > 1) ? $clog2(MAX_TRIES) : 1;
  localparam int SW      = xbrd_pkg::STATE_W;
  localparam int VW      = xbrd_pkg::VAL_W;

  logic [xbrd_pkg::OP_W-1:0]   op_r;
  logic [xbrd_pkg::LANE_W-1:0] lane_r;
  logic [SW-1:0]               seed_r;
  logic [VW-1:0]               lo_r, hi_r, mask_r;

  logic [SW-1:0]     s_r, rd_q;
  logic [TRY_W-1:0]  tries_r;
  logic              hit_r;
  logic [VW-1:0]     drawn_r;

  logic              out_tvalid_r;
  logic [VW-1:0]     out_drawn_r;
  logic [SW-1:0]     out_state_r;
  logic              out_gave_r;

  logic [SW-1:0]     mem [LANES];

  logic [8:0]         lane_ext;
  logic [LANE_AW-1:0] addr;
  logic               lane_ok;
  logic               is_draw;
  logic [SW-1:0]      s_step;
  logic [VW-1:0]      v;
  logic               hit_now;
  logic               out_free;

  assign lane_ext = {4'b0, lane_r};
  assign addr     = lane_ext[LANE_AW-1:0];
  assign lane_ok  = lane_ext < 9'(LANES);
  assign is_draw  = op_r == xbrd_pkg::OP_DRAW;
  assign s_step   = xbrd_pkg::xs_step(s_r);
  assign v        = s_step[VW-1:0] & mask_r;
  assign hit_now  = (v >= lo_r) && (v <= hi_r);
  assign out_free = !out_tvalid_r || out_tready;

  assign sts.is_draw  = is_draw;
  assign sts.lane_ok  = lane_ok;
  assign sts.hit      = hit_now;
  assign sts.last_try = tries_r == TRY_W'(MAX_TRIES - 1);
  assign sts.out_free = out_free;

  // item fields, lowest first: lane, seed_value, range_low, range_high, value_mask
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_tuser;
      lane_r <= in_tdata[4:0];
      seed_r <= in_tdata[68:5];
      lo_r   <= in_tdata[100:69];
      hi_r   <= in_tdata[132:101];
      mask_r <= in_tdata[164:133];
    end
  end

  // lane bank, registered read
  always_ff @(posedge clk) begin
    rd_q <= mem[addr];
    if (cmd.finish && lane_ok) begin
      mem[addr] <= s_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r     <= (op_r == xbrd_pkg::OP_SEED) ? seed_r : rd_q;
      tries_r <= '0;
      hit_r   <= 1'b0;
    end else if (cmd.step) begin
      s_r     <= s_step;
      tries_r <= tries_r + TRY_W'(1);
      hit_r   <= hit_now;
      drawn_r <= v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  // lane beyond the bank: all result fields zero
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_drawn_r <= (lane_ok && hit_r) ? drawn_r : '0;
      out_state_r <= lane_ok ? s_r : '0;
      out_gave_r  <= lane_ok && is_draw && !hit_r;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = {out_state_r, out_drawn_r};
  assign out_tuser[0] = out_gave_r;

  `XBRD_ASSERT_NOW(a_finish_room, clk, rst_n, cmd.finish, out_free)
  `XBRD_ASSERT_NEXT(a_finish_shown, clk, rst_n, cmd.finish, out_tvalid_r)
  `XBRD_ASSERT_NOW(a_giveup_zero, clk, rst_n, out_tvalid_r && out_gave_r, out_drawn_r == '0)
  `XBRD_ASSERT_NOW(a_step_draw, clk, rst_n, cmd.step, is_draw && lane_ok)

endmodule

>>> rtl/xbrd_ctrl.sv
module xbrd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  xbrd_pkg::sts_t sts,
  output xbrd_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_LOAD, S_STEP, S_FIN} state_t;

  state_t state_r;
  logic   in_tready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b1;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r     <= S_RD;
            in_tready_r <= 1'b0;
          end
        end
        S_RD:   state_r <= S_LOAD;
        S_LOAD: state_r <= (sts.is_draw && sts.lane_ok) ? S_STEP : S_FIN;
        S_STEP: begin
          if (sts.hit || sts.last_try) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (sts.out_free) begin
            state_r     <= S_IDLE;
            in_tready_r <= 1'b1;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          in_tready_r <= 1'b1;
        end
      endcase
    end
  end

  assign in_tready   = in_tready_r;
  assign cmd.capture = (state_r == S_IDLE) && in_tvalid;
  assign cmd.load    = state_r == S_LOAD;
  assign cmd.step    = state_r == S_STEP;
  assign cmd.finish  = (state_r == S_FIN) && sts.out_free;

endmodule

>>> tb/testbench.sv
module testbench;
  import xbrd_pkg::*;

  localparam int LANE_COUNT  = LANES_DEF;
  localparam int TRY_LIMIT   = MAX_TRIES_DEF;
  // quiet cycles allowed before the run is abandoned
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD   = 300;
  localparam int MAX_REPORTS = 40;

  // op code 3 has no name in the package; the block treats it as a read
  localparam logic [OP_W-1:0] OP_SPARE_READ = 2'd3;

  // idle modes for either side
  localparam int IDLE_NONE  = 0;
  localparam int IDLE_LIGHT = 1;
  localparam int IDLE_HEAVY = 2;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [LANE_W-1:0]  lane;
    logic [STATE_W-1:0] seed;
    logic [VAL_W-1:0]   lo;
    logic [VAL_W-1:0]   hi;
    logic [VAL_W-1:0]   mask;
  } lane_item_t;

  typedef struct {
    logic [VAL_W-1:0]   drawn;
    logic [STATE_W-1:0] state;
    logic               gave_up;
  } lane_outcome_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]        in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;

  logic [STATE_W-1:0] lane_bank [LANE_COUNT];
  lane_outcome_t      outcomes_due [$];
  int                 fails = 0;
  int                 quiet_cycles = 0;
  int                 src_idle_mode = IDLE_NONE;
  int                 sink_idle_mode = IDLE_NONE;
  int                 sink_hold_cycles = 0;

  xorshift_bank_range_draw u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic logic [STATE_W-1:0] xorshift_next(input logic [STATE_W-1:0] s);
    logic [STATE_W-1:0] t;
    t = s ^ (s << 13);
    t = t ^ (t >> 7);
    t = t ^ (t << 17);
    return t;
  endfunction

  // applies one item to the lane bank and returns what the block should send back
  function automatic lane_outcome_t run_lane_op(input lane_item_t it);
    lane_outcome_t      o;
    logic [STATE_W-1:0] s;
    logic [VAL_W-1:0]   v;
    bit                 hit;
    o.drawn   = '0;
    o.gave_up = 1'b0;
    s = lane_bank[it.lane];
    hit = 1'b0;
    case (it.op)
      OP_SEED: s = it.seed;
      OP_DRAW: begin
        for (int t = 0; t < TRY_LIMIT && !hit; t++) begin
          s = xorshift_next(s);
          v = s[VAL_W-1:0] & it.mask;
          if (v >= it.lo && v <= it.hi) begin
            o.drawn = v;
            hit = 1'b1;
          end
        end
        o.gave_up = !hit;
      end
      default: ;
    endcase
    lane_bank[it.lane] = s;
    o.state = s;
    return o;
  endfunction

  function automatic int pick_wait(input int mode);
    case (mode)
      IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
      IDLE_HEAVY: return $urandom_range(0, 17);
      default:    return 0;
    endcase
  endfunction

  function automatic lane_item_t lane_item(input logic [OP_W-1:0] op,
                                           input int lane,
                                           input logic [STATE_W-1:0] seed,
                                           input logic [VAL_W-1:0] lo,
                                           input logic [VAL_W-1:0] hi,
                                           input logic [VAL_W-1:0] mask);
    lane_item_t it;
    it.op = op;
    it.lane = LANE_W'(lane);
    it.seed = seed;
    it.lo = lo;
    it.hi = hi;
    it.mask = mask;
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [STATE_W-1:0] got,
                                 input logic [STATE_W-1:0] want);
    if (fails < MAX_REPORTS)
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    fails++;
  endtask

  // called and returns at a falling edge; valid is only lowered when a gap is drawn
  task automatic send_item(input lane_item_t it);
    int gap;
    gap = pick_wait(src_idle_mode);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, it.mask, it.hi, it.lo, it.seed, it.lane};
    in_tuser  <= it.op;
    do @(posedge clk); while (!in_tready);
    outcomes_due.push_back(run_lane_op(it));
    @(negedge clk);
  endtask

  // draw with mostly fitting mask and window, some noise and some empty ranges
  function automatic lane_item_t random_draw();
    lane_item_t      it;
    int unsigned     k;
    int unsigned     pick;
    logic [31:0]     m;
    logic [31:0]     tmp;
    longint unsigned top;
    it = lane_item(OP_DRAW, $urandom_range(0, LANE_COUNT - 1), {$urandom, $urandom},
                   $urandom, $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      k = $urandom_range(1, 32);
      m = (k == 32) ? 32'hFFFF_FFFF : ((32'd1 << k) - 32'd1);
      it.mask = m;
      it.lo = $urandom_range(0, m - (m >> 2));
      top = longint'(it.lo) + longint'(m >> 2) + longint'($urandom & (m >> 1));
      it.hi = (top > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : top[31:0];
    end else if (pick < 92) begin
      // raw values; about half the inverted windows are put right
      if (it.lo > it.hi && $urandom_range(0, 1) == 1) begin
        tmp = it.lo;
        it.lo = it.hi;
        it.hi = tmp;
      end
    end else begin
      it.hi = $urandom_range(0, 32'hFFFF_FFFE);
      it.lo = $urandom_range(it.hi + 1, 32'hFFFF_FFFF);
    end
    return it;
  endfunction

  task automatic test_seed_read();
    send_item(lane_item(OP_SEED, 0, 64'h0, 32'h0, 32'h0, 32'h0));
    send_item(lane_item(OP_SEED, 31, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(lane_item(OP_SEED, 5, 64'h0123_4567_89AB_CDEF, 32'h0, 32'h0, 32'h0));
    send_item(lane_item(OP_READ, 31, 64'h0, 32'h0, 32'h0, 32'h0));
    send_item(lane_item(OP_SPARE_READ, 0, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0, 32'h0));
    send_item(lane_item(OP_READ, 5, 64'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_draw_corners();
    // zero state on lane 0: accepts 0 when in range, otherwise gives up and stays 0; then lane 31 draws
    send_item(lane_item(OP_DRAW, 0, 64'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(lane_item(OP_DRAW, 0, 64'h0, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(lane_item(OP_DRAW, 31, 64'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(lane_item(OP_DRAW, 31, 64'h0, 32'h0, 32'h0, 32'h0));
    // empty range, then narrow and single-value ranges
    send_item(lane_item(OP_DRAW, 5, 64'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF));
    send_item(lane_item(OP_DRAW, 5, 64'h0, 32'h3, 32'h5, 32'hF));
    send_item(lane_item(OP_DRAW, 5, 64'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(lane_item(OP_DRAW, 31, 64'h0, 32'h8000_0000, 32'h8000_0001, 32'h8000_0001));
    send_item(lane_item(OP_READ, 5, 64'h0, 32'h0, 32'h0, 32'h0));
    send_item(lane_item(OP_SEED, 31, 64'h1, 32'h0, 32'h0, 32'h0));
    send_item(lane_item(OP_DRAW, 31, 64'h0, 32'h0, 32'hFF, 32'hFFFF_FFFF));
    send_item(lane_item(OP_SPARE_READ, 31, 64'h0, 32'h0, 32'h0, 32'h0));
  endtask

  task automatic test_random_traffic();
    int          src_modes [7] = '{IDLE_HEAVY, IDLE_NONE, IDLE_HEAVY, IDLE_LIGHT,
                                   IDLE_NONE, IDLE_HEAVY, IDLE_LIGHT};
    int          sink_modes [7] = '{IDLE_HEAVY, IDLE_HEAVY, IDLE_NONE, IDLE_LIGHT,
                                    IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY};
    int unsigned pick;
    lane_item_t  it;
    src_idle_mode = IDLE_LIGHT;
    sink_idle_mode = IDLE_LIGHT;
    // every lane gets a state before any draw or read touches it
    for (int l = 0; l < LANE_COUNT; l++)
      send_item(lane_item(OP_SEED, l, {$urandom, $urandom}, $urandom, $urandom, $urandom));
    for (int c = 0; c < 7; c++) begin
      src_idle_mode = src_modes[c];
      sink_idle_mode = sink_modes[c];
      for (int n = 0; n < 95; n++) begin
        pick = $urandom_range(0, 99);
        it = lane_item(OP_SEED, $urandom_range(0, LANE_COUNT - 1), {$urandom, $urandom},
                       $urandom, $urandom, $urandom);
        if (pick >= 15 && pick < 80)
          it = random_draw();
        else if (pick >= 80 && pick < 90)
          it.op = OP_READ;
        else if (pick >= 90)
          it.op = OP_SPARE_READ;
        send_item(it);
      end
    end
  endtask

  // receiver stops for a long stretch while items keep coming
  task automatic test_output_backpressure();
    lane_item_t it;
    src_idle_mode = IDLE_NONE;
    sink_idle_mode = IDLE_NONE;
    sink_hold_cycles = LONG_HOLD;
    for (int n = 0; n < 16; n++) begin
      if (n % 2 == 0)
        it = lane_item(OP_READ, $urandom_range(0, LANE_COUNT - 1), 64'h0, 32'h0, 32'h0, 32'h0);
      else
        it = lane_item(OP_DRAW, $urandom_range(0, LANE_COUNT - 1), 64'h0, 32'h0,
                       32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(it);
    end
  endtask

  // receiver: per item a random hold-off, then ready until a result is taken
  initial begin : result_sink
    int wait_n;
    @(negedge clk);
    forever begin
      if (sink_hold_cycles > 0) begin
        wait_n = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        wait_n = pick_wait(sink_idle_mode);
      end
      if (wait_n > 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    lane_outcome_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (outcomes_due.size() == 0) begin
        report_mismatch("result with nothing outstanding",
                        out_tdata[VAL_W+STATE_W-1:VAL_W], '0);
      end else begin
        due = outcomes_due.pop_front();
        if (out_tdata[VAL_W-1:0] !== due.drawn)
          report_mismatch("drawn_value", STATE_W'(out_tdata[VAL_W-1:0]),
                          STATE_W'(due.drawn));
        if (out_tdata[VAL_W+STATE_W-1:VAL_W] !== due.state)
          report_mismatch("lane_state", out_tdata[VAL_W+STATE_W-1:VAL_W], due.state);
        if (out_tuser[0] !== due.gave_up)
          report_mismatch("gave_up", STATE_W'(out_tuser[0]), STATE_W'(due.gave_up));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_seed_read();
    test_draw_corners();
    test_random_traffic();
    test_output_backpressure();
    in_tvalid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    // a stray extra result would show up within a few cycles
    repeat (20) @(posedge clk);
    if (outcomes_due.size() != 0)
      report_mismatch("results still outstanding", STATE_W'(outcomes_due.size()), '0);
    if (fails == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
